@@ rtl/tga_rle_pkg.sv @@
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; used by tga_rle_out_buf and tga_rle_pixel_decoder.
`default_nettype none

package tga_rle_pkg;

    // Configuration register indexes (register i at byte address 4*i).
    localparam int unsigned CFG_ADDR_W = 4;
    localparam logic [1:0] REG_PIXEL_BYTES  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Packet header decoding.
    localparam logic [7:0] HDR_RUN_BIT = 8'h80;
    localparam logic [7:0] RUN_BIAS    = 8'd127;
    localparam logic [7:0] RAW_BIAS    = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [2:0]  PIXEL_BYTES_RST  = 3'd3;
    localparam logic [15:0] IMAGE_WIDTH_RST  = 16'd1;
    localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd1;

    // One decoded result.
    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic        image_done;
    } t_pixel_result;

endpackage

`default_nettype wire

@@ rtl/tga_rle_pixel_decoder.sv @@
// TGA run-length pixel decoder: one compressed byte per cycle in while not stalled, decoded pixels out.
// A finished pixel is registered in the output buffer before it appears on the output.
// Throughput: one input byte per cycle, limited only by output stalls (two-entry buffer).
// Reset (synchronous, active low): 3 bytes per pixel, 1x1 image, next byte is a header.
// Depends on tga_rle_pkg and tga_rle_out_buf.
`default_nettype none

module tga_rle_pixel_decoder
    import tga_rle_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Compressed byte stream.
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [7:0]            i_in_byte,

    // Decoded pixel stream.
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [31:0]                o_pixel_value,
    output logic [7:0]                 o_repeat_count,
    output logic                       o_image_done,

    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // A write to the image width or height restarts decoding: the pixel
    // budget is reloaded with width times height and the next byte is
    // taken as a packet header. The product is formed from the incoming
    // write data and the other, unchanged register, so it is ready in
    // the same edge that stores the new size.
    // ------------------------------------------------------------------
    logic [2:0]  r_pixel_bytes;
    logic [15:0] r_image_width;
    logic [15:0] r_image_height;

    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic        wr_width;
    logic        wr_height;
    logic        restart;
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [31:0] image_size;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[3:2];
    assign wr_width  = cfg_wr && (cfg_idx == REG_IMAGE_WIDTH);
    assign wr_height = cfg_wr && (cfg_idx == REG_IMAGE_HEIGHT);
    assign restart   = wr_width || wr_height;

    assign mul_a      = wr_width  ? pwdata[15:0] : r_image_width;
    assign mul_b      = wr_height ? pwdata[15:0] : r_image_height;
    assign image_size = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes  <= PIXEL_BYTES_RST;
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PIXEL_BYTES:  r_pixel_bytes  <= pwdata[2:0];
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[15:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PIXEL_BYTES:  prdata = {29'd0, r_pixel_bytes};
            REG_IMAGE_WIDTH:  prdata = {16'd0, r_image_width};
            REG_IMAGE_HEIGHT: prdata = {16'd0, r_image_height};
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Decoder state.
    // Each transferred byte is decoded in a single pass of short logic:
    // a header byte loads the packet type and length, a pixel byte is
    // merged into the gather register, and the last byte of a pixel
    // produces a result that goes to the output buffer.
    // ------------------------------------------------------------------
    logic        r_expect_header;
    logic        r_packet_is_raw;
    logic [7:0]  r_packet_left;
    logic [1:0]  r_byte_index;
    logic [31:0] r_gather;
    logic [31:0] r_image_left;
    logic        r_finished;

    logic          in_xfer;
    logic          buf_full;
    logic [2:0]    eff_bytes;
    logic          pixel_done;
    logic [31:0]   gather_all;
    logic [7:0]    repeat_cnt;
    logic [7:0]    n_packet_left;
    logic [31:0]   n_image_left;
    logic          push;
    t_pixel_result result;

    assign o_stall = buf_full;
    assign in_xfer = i_valid && !o_stall;

    // Out-of-range pixel sizes: zero acts as one byte, five to seven as four.
    always_comb begin
        if (r_pixel_bytes == 3'd0) begin
            eff_bytes = 3'd1;
        end else if (r_pixel_bytes > 3'd4) begin
            eff_bytes = 3'd4;
        end else begin
            eff_bytes = r_pixel_bytes;
        end
    end

    assign gather_all = r_gather | ({24'd0, i_in_byte} << {r_byte_index, 3'b000});
    // The pixel completes when this byte is the last one of the current size;
    // a size shrunk mid-pixel completes it at once.
    assign pixel_done = !(({1'b0, r_byte_index} + 3'd1) < eff_bytes);

    // A run is clamped to the pixels still left in the image.
    always_comb begin
        if (r_packet_is_raw) begin
            repeat_cnt    = 8'd1;
            n_packet_left = r_packet_left - 8'd1;
        end else begin
            if ({24'd0, r_packet_left} > r_image_left) begin
                repeat_cnt = r_image_left[7:0];
            end else begin
                repeat_cnt = r_packet_left;
            end
            n_packet_left = 8'd0;
        end
        n_image_left = r_image_left - {24'd0, repeat_cnt};
    end

    assign push = in_xfer && !r_finished && !r_expect_header && pixel_done && !restart;

    assign result.pixel_value  = gather_all;
    assign result.repeat_count = repeat_cnt;
    assign result.image_done   = (n_image_left == 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header <= 1'b1;
            r_packet_is_raw <= 1'b0;
            r_packet_left   <= 8'd0;
            r_byte_index    <= 2'd0;
            r_gather        <= 32'd0;
            r_image_left    <= 32'd1;
            r_finished      <= 1'b0;
        end else if (restart) begin
            r_expect_header <= 1'b1;
            r_packet_is_raw <= 1'b0;
            r_packet_left   <= 8'd0;
            r_byte_index    <= 2'd0;
            r_gather        <= 32'd0;
            r_image_left    <= image_size;
            r_finished      <= (image_size == 32'd0);
        end else if (in_xfer && !r_finished) begin
            if (r_expect_header) begin
                r_packet_is_raw <= (i_in_byte < HDR_RUN_BIT);
                if (i_in_byte < HDR_RUN_BIT) begin
                    r_packet_left <= i_in_byte + RAW_BIAS;
                end else begin
                    r_packet_left <= i_in_byte - RUN_BIAS;
                end
                r_expect_header <= 1'b0;
                r_byte_index    <= 2'd0;
                r_gather        <= 32'd0;
            end else if (!pixel_done) begin
                r_gather     <= gather_all;
                r_byte_index <= r_byte_index + 2'd1;
            end else begin
                r_gather        <= 32'd0;
                r_byte_index    <= 2'd0;
                r_packet_left   <= n_packet_left;
                r_image_left    <= n_image_left;
                r_expect_header <= (n_packet_left == 8'd0);
                r_finished      <= (n_image_left == 32'd0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output buffer: lets a new byte transfer in while a finished pixel
    // still waits for the downstream side.
    // ------------------------------------------------------------------
    t_pixel_result out_data;

    tga_rle_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_data  (out_data),
        .i_stall (i_stall)
    );

    assign o_pixel_value  = out_data.pixel_value;
    assign o_repeat_count = out_data.repeat_count;
    assign o_image_done   = out_data.image_done;

endmodule

`default_nettype wire

@@ rtl/tga_rle_out_buf.sv @@
// Two-entry output buffer (output register plus skid register) for decoded results.
// Depends on tga_rle_pkg for the result struct.
`default_nettype none

module tga_rle_out_buf
    import tga_rle_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_pixel_result i_data,
    output logic               o_full,
    output logic               o_valid,
    output t_pixel_result      o_data,
    input  wire logic          i_stall
);

    logic          r_out_valid;
    logic          r_skid_valid;
    t_pixel_result r_out_data;
    t_pixel_result r_skid_data;
    logic          out_take;

    assign out_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            // The upstream side is held off while the skid entry is full,
            // so a push never arrives together with a full skid entry.
            if (r_skid_valid) begin
                if (out_take) begin
                    r_out_data   <= r_skid_data;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (!r_out_valid || out_take) begin
                    r_out_data  <= i_data;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_data  <= i_data;
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

`default_nettype wire

@@ dv/tga_rle_pixel_checker.sv @@
// Checker for the TGA run-length pixel decoder: snoops the byte, pixel and register channels,
// predicts every decoded pixel and compares it with what the decoder delivers.
// Depends on tga_rle_pkg for the register indexes, header constants and the result type.
`default_nettype none

module tga_rle_pixel_checker
    import tga_rle_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic [7:0]            i_in_byte,

    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [31:0]           i_pixel_value,
    input  wire logic [7:0]            i_repeat_count,
    input  wire logic                  i_image_done,

    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic                  i_pready,
    input  wire logic [CFG_ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]           i_pwdata,

    output int unsigned                o_fail_count,
    output int unsigned                o_pending,
    output int unsigned                o_pixels_seen,
    output int unsigned                o_bytes_decoded
);

    localparam int unsigned REPORT_LIMIT = 10;

    // Shadow copy of the configuration registers.
    logic [2:0]  cfg_pixel_bytes;
    logic [15:0] cfg_width;
    logic [15:0] cfg_height;

    // Shadow copy of the decoder state.
    logic        want_header;
    logic        raw_packet;
    logic [7:0]  packet_left;
    logic [1:0]  gather_idx;
    logic [31:0] gather_word;
    logic [31:0] image_left;
    logic        image_finished;

    t_pixel_result expected_pixels[$];
    int unsigned   fails = 0;
    int unsigned   pixels_seen = 0;
    int unsigned   bytes_decoded = 0;

    function automatic void restart_image();
        want_header    = 1'b1;
        raw_packet     = 1'b0;
        packet_left    = '0;
        gather_idx     = '0;
        gather_word    = '0;
        image_left     = 32'(cfg_width) * 32'(cfg_height);
        image_finished = (image_left == 0);
    endfunction

    // Advances the shadow state by one byte; returns 1 when a pixel comes out.
    function automatic bit decode_byte(input logic [7:0] b, output t_pixel_result px);
        logic [2:0]  px_size;
        logic [31:0] run_len;
        px = '0;
        if (image_finished)
            return 1'b0;
        if (want_header) begin
            raw_packet  = (b < HDR_RUN_BIT);
            packet_left = raw_packet ? b + RAW_BIAS : b - RUN_BIAS;
            want_header = 1'b0;
            gather_idx  = '0;
            gather_word = '0;
            return 1'b0;
        end
        // Out-of-range sizes saturate to the nearest legal one.
        px_size = (cfg_pixel_bytes == 3'd0) ? 3'd1 :
                  (cfg_pixel_bytes > 3'd4) ? 3'd4 : cfg_pixel_bytes;
        gather_word |= 32'(b) << {gather_idx, 3'b000};
        if (32'(gather_idx) + 1 < 32'(px_size)) begin
            gather_idx = gather_idx + 2'd1;
            return 1'b0;
        end
        px.pixel_value = gather_word;
        gather_idx     = '0;
        gather_word    = '0;
        if (raw_packet) begin
            run_len     = 32'd1;
            packet_left = packet_left - 8'd1;
        end else begin
            run_len     = (32'(packet_left) > image_left) ? image_left : 32'(packet_left);
            packet_left = '0;
        end
        image_left = image_left - run_len;
        if (packet_left == 0)
            want_header = 1'b1;
        image_finished  = (image_left == 0);
        px.repeat_count = run_len[7:0];
        px.image_done   = image_finished;
        return 1'b1;
    endfunction

    function automatic void report_pixel(input string what, input t_pixel_result want,
                                         input t_pixel_result got);
        fails++;
        if (fails <= REPORT_LIMIT)
            $display("%0t: %s: expected value %h repeat %0d done %0d, got value %h repeat %0d done %0d",
                     $time, what, want.pixel_value, want.repeat_count, want.image_done,
                     got.pixel_value, got.repeat_count, got.image_done);
    endfunction

    always @(posedge i_clk) begin
        t_pixel_result got;
        t_pixel_result want;
        if (!i_rst_n) begin
            cfg_pixel_bytes = PIXEL_BYTES_RST;
            cfg_width       = IMAGE_WIDTH_RST;
            cfg_height      = IMAGE_HEIGHT_RST;
            restart_image();
            expected_pixels.delete();
        end else begin
            // Outputs first: a pixel never leaves in the cycle its last byte arrives.
            got.pixel_value  = i_pixel_value;
            got.repeat_count = i_repeat_count;
            got.image_done   = i_image_done;
            if ($isunknown(i_out_valid)) begin
                report_pixel("unknown output valid", '0, got);
            end else if (i_out_valid && !i_out_stall) begin
                pixels_seen++;
                if (expected_pixels.size() == 0) begin
                    report_pixel("pixel with none expected", '0, got);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.pixel_value !== want.pixel_value ||
                        got.repeat_count !== want.repeat_count ||
                        got.image_done !== want.image_done)
                        report_pixel("pixel mismatch", want, got);
                end
            end

            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[CFG_ADDR_W-1:2])
                    REG_PIXEL_BYTES: begin
                        cfg_pixel_bytes = i_pwdata[2:0];
                    end
                    REG_IMAGE_WIDTH: begin
                        cfg_width = i_pwdata[15:0];
                        restart_image();
                    end
                    REG_IMAGE_HEIGHT: begin
                        cfg_height = i_pwdata[15:0];
                        restart_image();
                    end
                    default: begin
                    end
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                if (!image_finished)
                    bytes_decoded++;
                if (decode_byte(i_in_byte, want))
                    expected_pixels.push_back(want);
            end
        end
        o_fail_count    <= fails;
        o_pending       <= expected_pixels.size();
        o_pixels_seen   <= pixels_seen;
        o_bytes_decoded <= bytes_decoded;
    end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Top of the TGA run-length pixel decoder testbench: clock, reset, byte stimulus, output
// stalls and register writes. Depends on tga_rle_pkg, tga_rle_pixel_decoder and
// tga_rle_pixel_checker, which does all prediction and comparison.
`default_nettype none

module testbench;
    import tga_rle_pkg::*;

    // Number of bytes that must actually be decoded (not ignored) before the random
    // stimulus stops.
    localparam int unsigned BYTE_TARGET   = 1300;
    // Cycles to let pass after the last expected pixel before touching the registers;
    // the checker's pending count is registered and lags behind the decoder.
    localparam int unsigned SETTLE_CYCLES = 4;
    // Length of the long receiver hold-off that backs the decoder up into its input.
    localparam int unsigned HOLD_CYCLES   = 200;
    // Simulation time after which the run is stopped and reported as failed.
    localparam int unsigned TIMEOUT_TIME  = 2_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_in_byte = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [31:0]           o_pixel_value;
    logic [7:0]            o_repeat_count;
    logic                  o_image_done;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned pixels_seen;
    int unsigned bytes_decoded;

    // Bytes waiting to be offered to the decoder, in stream order.
    logic [7:0]  stream_q[$];
    // Set at each rising edge when the byte on offer was taken.
    logic        byte_taken = 1'b0;
    // The stimulus asks for a hold-off by bumping holds_asked; the stall process
    // answers by bumping holds_done once the hold-off is over.
    int unsigned holds_asked = 0;
    int unsigned holds_done = 0;
    int unsigned phase_count = 0;

    tga_rle_pixel_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_value  (o_pixel_value),
        .o_repeat_count (o_repeat_count),
        .o_image_done   (o_image_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    tga_rle_pixel_checker pixel_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_in_byte       (i_in_byte),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_pixel_value   (o_pixel_value),
        .i_repeat_count  (o_repeat_count),
        .i_image_done    (o_image_done),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_pixels_seen   (pixels_seen),
        .o_bytes_decoded (bytes_decoded)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        byte_taken <= i_valid && !o_stall;
    end

    // Byte sender. It works in bursts of random length separated by random gaps, and
    // about half of the bursts run straight into the next one with no gap at all.
    // A byte on offer is held unchanged until its transfer; only then may valid drop.
    initial begin
        int unsigned burst_left;
        int unsigned gap_left;
        burst_left = 1;
        gap_left   = 0;
        forever begin
            @(negedge i_clk);
            if (!i_valid || byte_taken) begin
                if (gap_left > 0) begin
                    i_valid <= 1'b0;
                    gap_left--;
                end else if (stream_q.size() > 0) begin
                    i_in_byte <= stream_q.pop_front();
                    i_valid   <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Pixel receiver. It switches between never stalling, sparse random stalls, a
    // fixed periodic pattern and heavy random stalls. When asked, it holds the
    // output off without a break so that the decoder fills up.
    initial begin
        int unsigned mode;
        int unsigned span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(40, 300);
            for (int c = 0; c < span; c++) begin
                @(negedge i_clk);
                if (holds_done != holds_asked) begin
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                    holds_done++;
                end else begin
                    case (mode)
                        0: i_stall <= 1'b0;
                        1: i_stall <= ($urandom_range(0, 3) == 0);
                        2: i_stall <= ((c % 7) < 3);
                        default: i_stall <= ($urandom_range(0, 9) < 7);
                    endcase
                end
            end
        end
    end

    // Waits until every byte has been transferred, every predicted pixel has come
    // out and any hold-off is over, then lets the checker's registered counts catch up.
    task automatic settle();
        while (stream_q.size() != 0 || i_valid || pending != 0 || holds_done != holds_asked)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic reg_write(input logic [1:0] reg_idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes all three registers. The upper bits of the data word are random: the
    // decoder must ignore everything above each register's width.
    task automatic set_format(input logic [2:0] px_bytes, input logic [15:0] width,
                              input logic [15:0] height);
        reg_write(REG_PIXEL_BYTES, {29'($urandom()), px_bytes});
        reg_write(REG_IMAGE_WIDTH, {16'($urandom()), width});
        reg_write(REG_IMAGE_HEIGHT, {16'($urandom()), height});
    endtask

    task automatic push_bytes(input logic [7:0] bytes[$]);
        foreach (bytes[k])
            stream_q.push_back(bytes[k]);
    endtask

    // Queues a well-formed compressed image of random raw and run packets with random
    // pixel contents. Packets are mostly short with an occasional long one, and the
    // last packet may run past the end of the image. For images too large to finish,
    // generation stops once byte_budget bytes have been queued.
    task automatic queue_image(input int unsigned px_bytes, input longint unsigned pixels,
                               input int unsigned byte_budget);
        longint unsigned left;
        int unsigned     queued;
        int unsigned     count;
        left   = pixels;
        queued = 0;
        while (left > 0 && queued < byte_budget) begin
            count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
            if ($urandom_range(0, 1) == 0) begin
                stream_q.push_back(8'(count) - RAW_BIAS);
                repeat (count * px_bytes) stream_q.push_back(8'($urandom()));
                queued += 1 + count * px_bytes;
            end else begin
                stream_q.push_back(8'(count) + RUN_BIAS);
                repeat (px_bytes) stream_q.push_back(8'($urandom()));
                queued += 1 + px_bytes;
            end
            left = (left > count) ? left - count : 0;
        end
    endtask

    // One random phase: a fresh image format, then a stream for it. Most phases are
    // complete images, some end in stray bytes after the image, some are cut off in
    // the middle of a packet and a few are plain noise.
    task automatic random_phase();
        logic [2:0]  px_bytes;
        logic [15:0] width;
        logic [15:0] height;
        int unsigned eff_bytes;
        int unsigned shape;
        px_bytes = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(1, 4))
                                              : 3'($urandom_range(0, 7));
        case ($urandom_range(0, 19))
            0: width = 16'hFFFF;
            1: width = '0;
            2: width = 16'($urandom());
            default: width = 16'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 19))
            0: height = 16'hFFFF;
            1: height = '0;
            default: height = 16'($urandom_range(1, 6));
        endcase
        eff_bytes = (px_bytes == 0) ? 1 : (px_bytes > 4) ? 4 : px_bytes;
        set_format(px_bytes, width, height);
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            repeat ($urandom_range(20, 60)) stream_q.push_back(8'($urandom()));
        end else begin
            queue_image(eff_bytes, longint'(width) * longint'(height), 200);
            if (shape == 1) begin
                // Broken stream: a header and part of a pixel, never completed.
                stream_q.push_back(8'($urandom()));
                repeat ($urandom_range(0, eff_bytes - 1)) stream_q.push_back(8'($urandom()));
            end else if (shape <= 4) begin
                repeat ($urandom_range(1, 4)) stream_q.push_back(8'($urandom()));
            end
        end
        phase_count++;
        settle();
    endtask

    initial begin
        #(TIMEOUT_TIME);
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Reset format: three bytes per pixel, 1x1 image. A raw packet
        // of one pixel finishes the image at once, and the stray byte after it is dropped.
        push_bytes({8'h00, 8'h00, 8'hFF, 8'h80, 8'h12});
        settle();

        // Run of 128 on a four-pixel image: the repeat count is clamped to 4.
        set_format(3'd1, 16'd4, 16'd1);
        push_bytes({8'hFF, 8'h5A});
        settle();

        // Raw packet of 128 on a two-pixel image: the third pixel is past the end.
        set_format(3'd1, 16'd2, 16'd1);
        push_bytes({8'h7F, 8'h01, 8'h02, 8'h03});
        settle();

        // Zero width: every byte is ignored.
        set_format(3'd1, 16'd0, 16'd1);
        push_bytes({8'h00, 8'h33});
        settle();

        // Pixel size zero acts as one byte: a short run, then a raw pixel to finish.
        set_format(3'd0, 16'd3, 16'd1);
        push_bytes({8'h81, 8'h44, 8'h00, 8'h55});
        settle();

        // Pixel size seven acts as four, on the largest image.
        set_format(3'd7, 16'hFFFF, 16'hFFFF);
        push_bytes({8'h80, 8'h11, 8'h22, 8'h33, 8'h44});
        settle();

        // Pixel size shrinks while a pixel is half gathered: three of four bytes are
        // in, the size drops to two, and the very next byte completes the pixel.
        reg_write(REG_PIXEL_BYTES, 32'd4);
        push_bytes({8'h00, 8'hA1, 8'hB2, 8'hC3});
        settle();
        reg_write(REG_PIXEL_BYTES, 32'd2);
        push_bytes({8'hD4});
        settle();

        // Back pressure: one-byte pixels stream in while the receiver holds off
        // for a long stretch, so the decoder's buffer fills and it stalls its input.
        set_format(3'd1, 16'd1000, 16'd1);
        holds_asked++;
        queue_image(1, 1000, 300);
        settle();

        while (bytes_decoded < BYTE_TARGET)
            random_phase();

        repeat (10) @(negedge i_clk);
        $display("Decoded %0d stream bytes into %0d pixel transfers over %0d random formats,",
                 bytes_decoded, pixels_seen, phase_count);
        $display("with bursty input, mixed output stalls and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/tga_rle_pkg.sv
rtl/tga_rle_out_buf.sv
rtl/tga_rle_pixel_decoder.sv
dv/tga_rle_pixel_checker.sv
dv/testbench.sv
